/* rtl/core/abl_pkg.sv */
// Shared types and constants for the alternating-bit link control block.
// No dependencies; imported by every module under rtl/core.
package abl_pkg;

   localparam logic [7:0]  HEADER_BYTES = 8'd10;
   localparam logic [15:0] MAGIC_WORD   = 16'd44203;

   typedef enum logic [1:0] {
      OP_RECEIVE = 2'd0,
      OP_SEND    = 2'd1,
      OP_LOAD    = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      MODE_OFF     = 2'd0,
      MODE_PASSIVE = 2'd1,
      MODE_ACTIVE  = 2'd2
   } mode_type;

   localparam logic [1:0] DELAY_WAKE  = 2'd0;
   localparam logic [1:0] DELAY_SHORT = 2'd1;
   localparam logic [1:0] DELAY_LONG  = 2'd2;

   localparam logic [1:0] RP_NONE = 2'd0;
   localparam logic [1:0] RP_ONE  = 2'd1;
   localparam logic [1:0] RP_TWO  = 2'd2;

   // Classified beat, as queued between front and back
   typedef struct packed {
      logic [1:0] op;
      logic       magic_ok;
      logic       payload;   // packet carries bytes beyond the header
      logic       len_ok;    // length field nonzero and fits
      logic       bok;
      logic       load_ok;   // buffer obtained and nonzero length
      logic [7:0] plen;
      logic [7:0] pcur;
      logic [7:0] pexp;
      logic [7:0] olen;
   } item_type;

   // Result beat
   typedef struct packed {
      logic       send_now;
      logic [7:0] tx_length;
      logic [7:0] tx_current;
      logic [7:0] tx_expected;
      logic [1:0] retry_delay;
      logic       delivered;
      logic [7:0] delivered_length;
      logic       out_done;
      logic       wake;
      logic       foreign;
   } result_type;

   // Queue handshake towards either side
   typedef struct packed {
      logic full;
      logic valid;
   } q_status_type;

endpackage

/* rtl/core/abl_front.sv */
// Front end: takes request beats and classifies them (state independent checks).
// Depends on abl_pkg.
module abl_front
   import abl_pkg::*;
(
   input  logic         req_valid,
   input  q_status_type q_status,
   input  logic [1:0]   req_operation,
   input  logic [15:0]  req_pkt_magic,
   input  logic [7:0]   req_pkt_length,
   input  logic [7:0]   req_pkt_current,
   input  logic [7:0]   req_pkt_expected,
   input  logic [7:0]   req_pkt_bytes_left,
   input  logic         req_buffer_ok,
   input  logic [7:0]   req_out_length,
   output logic         req_ready,
   output logic         push,
   output item_type     push_item
);

   logic [8:0] need;

   assign req_ready = !q_status.full;
   assign push      = req_valid && !q_status.full;

   // length plus header must fit in the bytes received
   assign need = {1'b0, req_pkt_length} + {1'b0, HEADER_BYTES};

   always_comb begin
      push_item.op       = req_operation;
      push_item.magic_ok = (req_pkt_magic == MAGIC_WORD);
      push_item.payload  = (req_pkt_bytes_left > HEADER_BYTES);
      push_item.len_ok   = (req_pkt_length != 8'd0) && (need <= {1'b0, req_pkt_bytes_left});
      push_item.bok      = req_buffer_ok;
      push_item.load_ok  = req_buffer_ok && (req_out_length != 8'd0);
      push_item.plen     = req_pkt_length;
      push_item.pcur     = req_pkt_current;
      push_item.pexp     = req_pkt_expected;
      push_item.olen     = req_out_length;
   end

endmodule

/* rtl/core/abl_queue.sv */
// Two-entry queue decoupling the classifier from the execution stage.
// Depends on abl_pkg.
module abl_queue
   import abl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  item_type     push_item,
   input  logic         pop,
   output q_status_type q_status,
   output item_type     head_item
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;

   assign q_status.full  = (count_ff == 2'd2);
   assign q_status.valid = (count_ff != 2'd0);
   assign head_item      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !push)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !q_status.valid |-> !pop)
      else $error("queue pop while empty");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

endmodule

/* rtl/core/abl_back.sv */
// Execution stage: link state, mode register and the registered result beat.
// Depends on abl_pkg.
module abl_back
   import abl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_wr_data,
   input  q_status_type q_status,
   input  item_type     head_item,
   input  logic         rsp_ready,
   output logic         pop,
   output logic         rsp_valid,
   output result_type   rsp_beat
);

   mode_type   mode_ff, mode_in;
   logic [7:0] cur_ff,  cur_in;
   logic [7:0] exp_ff,  exp_in;
   logic [7:0] pend_ff, pend_in;
   logic [1:0] rp_ff,   rp_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff,  res_in;

   assign pop       = q_status.valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

   always_comb begin
      if (!csr_wr_en) begin
         mode_in = mode_ff;
      end else if (csr_wr_data == 2'd3) begin
         mode_in = MODE_ACTIVE;   // top code folds onto active
      end else begin
         mode_in = mode_type'(csr_wr_data);
      end
   end

   always_comb begin
      cur_in  = cur_ff;
      exp_in  = exp_ff;
      pend_in = pend_ff;
      rp_in   = rp_ff;
      res_in  = '0;
      unique case (head_item.op)
         OP_RECEIVE: begin
            if (!head_item.magic_ok) begin
               res_in.foreign = 1'b1;
            end else begin
               // ack / nak of our outgoing message
               if (pend_ff != 8'd0) begin
                  if (head_item.pexp != cur_ff) begin
                     pend_in         = 8'd0;
                     rp_in           = RP_NONE;
                     res_in.out_done = 1'b1;
                     cur_in          = head_item.pexp;
                  end else begin
                     if (rp_ff == RP_NONE) begin
                        rp_in = RP_ONE;
                     end
                     res_in.wake = 1'b1;
                  end
               end else begin
                  cur_in = head_item.pexp;
               end
               // payload part
               if (head_item.payload) begin
                  if (rp_in == RP_NONE) begin
                     rp_in = RP_ONE;
                  end
                  res_in.wake = 1'b1;
                  if (head_item.pcur == exp_ff && head_item.len_ok && head_item.bok) begin
                     res_in.delivered        = 1'b1;
                     res_in.delivered_length = head_item.plen;
                     exp_in                  = exp_ff + 8'd1;
                  end
               end
            end
         end
         OP_SEND: begin
            if (mode_ff == MODE_PASSIVE) begin
               if (rp_ff != RP_NONE) begin
                  if (head_item.bok) begin
                     res_in.send_now    = 1'b1;
                     res_in.tx_length   = pend_ff;
                     res_in.tx_current  = cur_ff;
                     res_in.tx_expected = exp_ff;
                     rp_in              = rp_ff - 2'd1;
                     if (rp_ff != RP_ONE) begin
                        res_in.retry_delay = DELAY_LONG;
                     end
                  end else begin
                     res_in.retry_delay = DELAY_SHORT;
                  end
               end
            end else if (mode_ff == MODE_ACTIVE) begin
               if (head_item.bok) begin
                  res_in.send_now    = 1'b1;
                  res_in.tx_length   = pend_ff;
                  res_in.tx_current  = cur_ff;
                  res_in.tx_expected = exp_ff;
                  res_in.retry_delay = DELAY_LONG;
               end else begin
                  res_in.retry_delay = DELAY_SHORT;
               end
               if (rp_ff != RP_NONE) begin
                  rp_in = rp_ff - 2'd1;
               end
            end
         end
         OP_LOAD: begin
            if (head_item.load_ok && pend_ff == 8'd0) begin
               pend_in     = head_item.olen;
               rp_in       = RP_TWO;
               res_in.wake = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_OFF;
         cur_ff       <= 8'd0;
         exp_ff       <= 8'd0;
         pend_ff      <= 8'd0;
         rp_ff        <= RP_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            cur_ff  <= cur_in;
            exp_ff  <= exp_in;
            pend_ff <= pend_in;
            rp_ff   <= rp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= res_in;
      end
   end

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !pop)
      else $error("result overwritten while stalled");

   a_tx_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.send_now) |->
         (rsp_ff.tx_length == 8'd0 && rsp_ff.tx_current == 8'd0 &&
          rsp_ff.tx_expected == 8'd0))
      else $error("header fields set without a send");

   a_foreign_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.foreign) |->
         (!rsp_ff.wake && !rsp_ff.delivered && !rsp_ff.out_done && !rsp_ff.send_now))
      else $error("foreign packet had side effects");

   a_mode_fold: assert property (@(posedge clock) disable iff (reset)
      (csr_wr_en && csr_wr_data == 2'd3) |=> (mode_ff == MODE_ACTIVE))
      else $error("mode code 3 not folded to active");

endmodule

/* rtl/core/alternating_bit_link_control.sv */
// Top level of the alternating-bit link control block.
// Depends on abl_pkg, abl_front, abl_queue and abl_back.
//
// Usage:
//   req_* is the event channel (valid/ready): a received header, a send
//   opportunity or a new outgoing message. Every accepted beat yields exactly
//   one beat on rsp_* (valid/ready), in order.
//   csr_wr_en/csr_wr_data write the link mode (off, passive, active); write it
//   only while the block is idle. Code 3 is stored as active.
//   An accepted beat is written into the queue, moved into the result register
//   when the output is free, and presented on rsp_* from that register.
//   Throughput: one beat per cycle while rsp_ready is high, as the sequence and
//   pending registers in the execution stage are updated on every pop.
//   The classifier feeds a two-entry queue; req_ready is low only when that
//   queue is full, so with rsp_ready held low two further beats are taken
//   (plus the one held in the output register) before the input stalls.
//   Reset (synchronous, active high) clears the sequence numbers, the pending
//   message, the reply counter, the mode and the queue; no sweep is needed.
module alternating_bit_link_control
   import abl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_pkt_magic,
   input  logic [7:0]  req_pkt_length,
   input  logic [7:0]  req_pkt_current,
   input  logic [7:0]  req_pkt_expected,
   input  logic [7:0]  req_pkt_bytes_left,
   input  logic        req_buffer_ok,
   input  logic [7:0]  req_out_length,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_send_now,
   output logic [7:0]  rsp_tx_length,
   output logic [7:0]  rsp_tx_current,
   output logic [7:0]  rsp_tx_expected,
   output logic [1:0]  rsp_retry_delay,
   output logic        rsp_delivered,
   output logic [7:0]  rsp_delivered_length,
   output logic        rsp_out_done,
   output logic        rsp_wake,
   output logic        rsp_foreign
);

   q_status_type q_status;
   logic         push;
   logic         pop;
   item_type     push_item;
   item_type     head_item;
   result_type   rsp_beat;

   // classify incoming beats
   abl_front u_front (
      .req_valid          (req_valid),
      .q_status           (q_status),
      .req_operation      (req_operation),
      .req_pkt_magic      (req_pkt_magic),
      .req_pkt_length     (req_pkt_length),
      .req_pkt_current    (req_pkt_current),
      .req_pkt_expected   (req_pkt_expected),
      .req_pkt_bytes_left (req_pkt_bytes_left),
      .req_buffer_ok      (req_buffer_ok),
      .req_out_length     (req_out_length),
      .req_ready          (req_ready),
      .push               (push),
      .push_item          (push_item)
   );

   // decoupling queue
   abl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .q_status  (q_status),
      .head_item (head_item)
   );

   // state update and result register
   abl_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_status    (q_status),
      .head_item   (head_item),
      .rsp_ready   (rsp_ready),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_beat    (rsp_beat)
   );

   // unpack result beat onto ports
   assign rsp_send_now         = rsp_beat.send_now;
   assign rsp_tx_length        = rsp_beat.tx_length;
   assign rsp_tx_current       = rsp_beat.tx_current;
   assign rsp_tx_expected      = rsp_beat.tx_expected;
   assign rsp_retry_delay      = rsp_beat.retry_delay;
   assign rsp_delivered        = rsp_beat.delivered;
   assign rsp_delivered_length = rsp_beat.delivered_length;
   assign rsp_out_done         = rsp_beat.out_done;
   assign rsp_wake             = rsp_beat.wake;
   assign rsp_foreign          = rsp_beat.foreign;

endmodule
